### design/y86_pkg.sv
// Shared types, opcodes and decode helpers for the Y86 instruction executor.
package y86_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // Machine status codes
    localparam logic [1:0] STAT_RUN = 2'd0;
    localparam logic [1:0] STAT_HLT = 2'd1;
    localparam logic [1:0] STAT_ADR = 2'd2;
    localparam logic [1:0] STAT_INS = 2'd3;

    // Output kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_LONG = 2'd2;

    // Stack pointer register index
    localparam logic [2:0] REG_ESP = 3'd4;

    // Opcodes
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_HALT  = 8'h10;
    localparam logic [7:0] OP_RRMOV = 8'h20;
    localparam logic [7:0] OP_IRMOV = 8'h30;
    localparam logic [7:0] OP_RMMOV = 8'h40;
    localparam logic [7:0] OP_MRMOV = 8'h50;
    localparam logic [7:0] OP_ADD   = 8'h60;
    localparam logic [7:0] OP_SUB   = 8'h61;
    localparam logic [7:0] OP_AND   = 8'h62;
    localparam logic [7:0] OP_XOR   = 8'h63;
    localparam logic [7:0] OP_MUL   = 8'h64;
    localparam logic [7:0] OP_CMP   = 8'h65;
    localparam logic [7:0] OP_JMP   = 8'h70;
    localparam logic [7:0] OP_JLE   = 8'h71;
    localparam logic [7:0] OP_JL    = 8'h72;
    localparam logic [7:0] OP_JE    = 8'h73;
    localparam logic [7:0] OP_JNE   = 8'h74;
    localparam logic [7:0] OP_JGE   = 8'h75;
    localparam logic [7:0] OP_JG    = 8'h76;
    localparam logic [7:0] OP_CALL  = 8'h80;
    localparam logic [7:0] OP_RET   = 8'h90;
    localparam logic [7:0] OP_PUSH  = 8'ha0;
    localparam logic [7:0] OP_POP   = 8'hb0;
    localparam logic [7:0] OP_RDB   = 8'hc0;
    localparam logic [7:0] OP_RDL   = 8'hc1;
    localparam logic [7:0] OP_WRB   = 8'hd0;
    localparam logic [7:0] OP_WRL   = 8'hd1;
    localparam logic [7:0] OP_MOVSB = 8'he0;

    // ALU function, taken from the low opcode bits of the 0x6X group
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_AND = 3'd2,
        ALU_XOR = 3'd3,
        ALU_MUL = 3'd4,
        ALU_CMP = 3'd5
    } alu_fn_t;

    typedef struct packed {
        logic ovf;
        logic sf;
        logic zf;
    } flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_DECODE,
        ST_FETCH,
        ST_REGS,
        ST_ADDR,
        ST_LOAD,
        ST_STORE,
        ST_WB,
        ST_WB2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               ok;
        logic [2:0]         len;
        logic [1:0]         regs_used;  // bit 0: rA, bit 1: rB
    } decode_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        address;
        logic [7:0]         byte_value;
        logic signed [31:0] read_value;
        logic               read_end;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [11:0]        pc_now;
        logic [1:0]         out_kind;
        logic signed [31:0] out_value;
    } result_t;

    // Instruction length and register nibble usage per opcode
    function automatic decode_t y86_decode(input logic [7:0] op);
        decode_t d;
        d = '{ok: 1'b1, len: 3'd1, regs_used: 2'b00};
        case (op) inside
            OP_NOP, OP_HALT, OP_RET:       d.len = 3'd1;
            OP_RRMOV, [OP_ADD:OP_CMP]:     begin d.len = 3'd2; d.regs_used = 2'b11; end
            OP_IRMOV:                      begin d.len = 3'd6; d.regs_used = 2'b10; end
            OP_RMMOV, OP_MRMOV, OP_MOVSB:  begin d.len = 3'd6; d.regs_used = 2'b11; end
            [OP_JMP:OP_JG], OP_CALL:       d.len = 3'd5;
            OP_PUSH, OP_POP:               begin d.len = 3'd2; d.regs_used = 2'b01; end
            OP_RDB, OP_RDL, OP_WRB, OP_WRL: begin d.len = 3'd6; d.regs_used = 2'b01; end
            default:                       d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### design/y86_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module y86_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/y86_alu.sv
// Y86 ALU: add, subtract, and, xor, compare and signed multiply, one register stage.
module y86_alu (
    input  logic                  clk,
    input  y86_pkg::alu_fn_t      fn,
    input  logic [31:0]           x,
    input  logic [31:0]           y,
    output logic [31:0]           r,
    output y86_pkg::flags_t       flags
);
    import y86_pkg::*;

    alu_fn_t     fn_reg;
    logic [31:0] sum_reg;
    logic        ovf_reg;
    logic [63:0] prod_reg;
    logic [31:0] sum_next;
    logic        ovf_next;

    // simple ops: y op x
    always_comb
    begin
        sum_next = 32'd0;
        ovf_next = 1'b0;
        case (fn)
            ALU_ADD:
            begin
                sum_next = y + x;
                ovf_next = (~(x[31] ^ y[31])) & (x[31] ^ sum_next[31]);
            end
            ALU_SUB, ALU_CMP:
            begin
                sum_next = y - x;
                ovf_next = (x[31] ^ y[31]) & (y[31] ^ sum_next[31]);
            end
            ALU_AND: sum_next = x & y;
            ALU_XOR: sum_next = x ^ y;
            default: sum_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        fn_reg   <= fn;
        sum_reg  <= sum_next;
        ovf_reg  <= ovf_next;
        prod_reg <= 64'($signed(x) * $signed(y));
    end

    // result select; multiply overflows when the high word is not the sign extension
    always_comb
    begin
        if (fn_reg == ALU_MUL)
        begin
            r         = prod_reg[31:0];
            flags.ovf = prod_reg[63:32] != {32{prod_reg[31]}};
        end
        else
        begin
            r         = sum_reg;
            flags.ovf = ovf_reg;
        end
        flags.zf = r == 32'd0;
        flags.sf = r[31];
    end

endmodule

### design/y86_instruction_executor.sv
// Top level of the Y86 instruction executor: sequencer, byte memory and register file.
//
// One item is taken when start is high and busy is low; its single result is shown for
// one cycle with done high and cannot be held off. Load, start-address and non-running
// items go from idle straight to the result state. For an executed instruction, every
// instruction byte (1 to 6) and every data byte (up to 4) passes through the byte-wide
// memory port one per cycle, register operands are read one per cycle, and a pop writes
// two registers through the single register file write port. Halt and faults end the
// item early.
module y86_instruction_executor #(
    parameter int MEM_BYTES = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  y86_pkg::item_t   item,
    output logic             done,
    output y86_pkg::result_t result
);
    import y86_pkg::*;

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int PCW = (AW > 12) ? AW : 12;
    localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg;
    logic [7:0]  ib_reg [6];
    logic [2:0]  len_reg;
    logic [1:0]  used_reg;
    logic [31:0] x_reg, y_reg, sp_reg, a_reg, nx_reg, wval_reg, ld_reg, rv_reg;
    logic [2:0]  n_reg;
    logic        rend_reg;
    logic [PCW-1:0] pc_reg;
    logic [1:0]  status_reg;
    flags_t      flags_reg;
    logic [1:0]  kind_reg;
    logic [31:0] val_reg;
    logic [7:0]  rvalid_reg;
    logic        rvld_q_reg;

    logic        accept;
    logic [7:0]  op;
    logic [3:0]  ra, rb;
    decode_t     dec;
    logic        pc_fault, fetch_fault, nib_fault, data_fault, nx_fault, ret_fault;
    logic [31:0] imm;
    logic [31:0] a_c, nx_c;
    logic [2:0]  n_c;
    logic        take;
    logic        load_need, store_need;
    logic [1:0]  ld_idx;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    // register file ports
    logic          rf_we;
    logic [2:0]    rf_waddr, rf_raddr;
    logic [31:0]   rf_wdata, rf_rdata_raw, rf_rdata;
    // ALU
    logic [31:0]   alu_r;
    flags_t        alu_flags;

    y86_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    y86_ram #(.WIDTH(32), .DEPTH(8)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata_raw)
    );

    y86_alu u_alu (
        .clk   (clk),
        .fn    (alu_fn_t'(ib_reg[0][2:0])),
        .x     (x_reg),
        .y     (y_reg),
        .r     (alu_r),
        .flags (alu_flags)
    );

    // decode and fault checks
    assign accept   = start && !busy;
    assign op       = ib_reg[0];
    assign ra       = ib_reg[1][7:4];
    assign rb       = ib_reg[1][3:0];
    assign dec      = y86_decode(mem_rdata);
    assign rf_rdata = rvld_q_reg ? rf_rdata_raw : 32'd0;
    assign imm      = (len_reg == 3'd6) ? {ib_reg[5], ib_reg[4], ib_reg[3], ib_reg[2]}
                                        : {ib_reg[4], ib_reg[3], ib_reg[2], ib_reg[1]};
    assign pc_fault    = 33'(pc_reg) >= MEM_LIM;
    assign fetch_fault = 33'(pc_reg) + 33'(dec.len) > MEM_LIM;
    assign nib_fault   = (used_reg[0] && ra[3]) || (used_reg[1] && rb[3]);
    assign ld_idx      = 2'(cnt_reg - 3'd1);

    // data address, size and branch decision
    always_comb
    begin
        a_c  = 32'd0;
        n_c  = 3'd0;
        take = 1'b0;
        case (op)
            OP_RMMOV, OP_MRMOV: begin a_c = y_reg + imm; n_c = 3'd4; end
            OP_MOVSB:           begin a_c = y_reg + imm; n_c = 3'd1; end
            OP_RDB, OP_WRB:     begin a_c = x_reg + imm; n_c = 3'd1; end
            OP_RDL, OP_WRL:     begin a_c = x_reg + imm; n_c = 3'd4; end
            OP_CALL, OP_PUSH:   begin a_c = sp_reg - 32'd4; n_c = 3'd4; end
            OP_RET, OP_POP:     begin a_c = sp_reg; n_c = 3'd4; end
            OP_JMP:             take = 1'b1;
            OP_JLE:             take = (flags_reg.sf ^ flags_reg.ovf) | flags_reg.zf;
            OP_JL:              take = flags_reg.sf ^ flags_reg.ovf;
            OP_JE:              take = flags_reg.zf;
            OP_JNE:             take = !flags_reg.zf;
            OP_JGE:             take = !(flags_reg.sf ^ flags_reg.ovf);
            OP_JG:              take = !(flags_reg.sf ^ flags_reg.ovf) && !flags_reg.zf;
            default:            take = 1'b0;
        endcase
        nx_c = (op == OP_CALL || take) ? imm : 32'(pc_reg) + 32'(len_reg);
    end

    assign data_fault = (n_c != 3'd0) && (33'(a_c) + 33'(n_c) > MEM_LIM);
    assign nx_fault   = (op != OP_RET) && (33'(nx_c) >= MEM_LIM);
    assign ret_fault  = 33'(ld_reg) >= MEM_LIM;
    assign load_need  = op inside {OP_MRMOV, OP_POP, OP_RET, OP_WRB, OP_WRL, OP_MOVSB};
    assign store_need = (op inside {OP_RMMOV, OP_CALL, OP_PUSH})
                        || ((op inside {OP_RDB, OP_RDL}) && !rend_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (item.cmd == CMD_EXEC && status_reg == STAT_RUN)
                        state_next = ST_FETCH0;
                    else
                        state_next = ST_DONE;
                end
            ST_FETCH0:
                state_next = pc_fault ? ST_DONE : ST_DECODE;
            ST_DECODE:
                if (!dec.ok || fetch_fault || mem_rdata == OP_HALT)
                    state_next = ST_DONE;
                else if (dec.len == 3'd1)
                    state_next = ST_REGS;
                else
                    state_next = ST_FETCH;
            ST_FETCH:
                if (cnt_reg == len_reg - 3'd1)
                    state_next = ST_REGS;
            ST_REGS:
                if (cnt_reg == 3'd0 && nib_fault)
                    state_next = ST_DONE;
                else if (cnt_reg == 3'd3)
                    state_next = ST_ADDR;
            ST_ADDR:
                if (data_fault || nx_fault)
                    state_next = ST_DONE;
                else if (load_need)
                    state_next = ST_LOAD;
                else if (store_need)
                    state_next = ST_STORE;
                else
                    state_next = ST_WB;
            ST_LOAD:
                if (cnt_reg == n_reg)
                    state_next = ST_WB;
            ST_STORE:
                if (cnt_reg == n_reg - 3'd1)
                    state_next = ST_WB;
            ST_WB:
                if (op == OP_POP)
                    state_next = ST_WB2;
                else
                    state_next = ST_DONE;
            ST_WB2:
                state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory and register file port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = a_reg[AW-1:0] + AW'(cnt_reg);
        mem_wdata = wval_reg[{cnt_reg[1:0], 3'b000} +: 8];
        mem_raddr = pc_reg[AW-1:0];
        rf_we     = 1'b0;
        rf_waddr  = REG_ESP;
        rf_wdata  = a_reg;
        rf_raddr  = REG_ESP;
        case (state_reg)
            ST_IDLE:
            begin
                mem_waddr = AW'(item.address);
                mem_wdata = item.byte_value;
                mem_we    = accept && item.cmd == CMD_LOAD && 33'(item.address) < MEM_LIM;
            end
            ST_DECODE: mem_raddr = pc_reg[AW-1:0] + AW'(1);
            ST_FETCH:  mem_raddr = pc_reg[AW-1:0] + AW'(cnt_reg) + AW'(1);
            ST_LOAD:   mem_raddr = a_reg[AW-1:0] + AW'(cnt_reg);
            ST_STORE:  mem_we = 1'b1;
            ST_REGS:
                case (cnt_reg)
                    3'd0:    rf_raddr = ra[2:0];
                    3'd1:    rf_raddr = rb[2:0];
                    default: rf_raddr = REG_ESP;
                endcase
            ST_WB:
                if (!(op == OP_RET && ret_fault))
                begin
                    case (op)
                        OP_RRMOV:
                        begin rf_we = 1'b1; rf_waddr = rb[2:0]; rf_wdata = x_reg; end
                        OP_IRMOV:
                        begin rf_we = 1'b1; rf_waddr = rb[2:0]; rf_wdata = imm; end
                        OP_MRMOV:
                        begin rf_we = 1'b1; rf_waddr = ra[2:0]; rf_wdata = ld_reg; end
                        OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_MUL:
                        begin rf_we = 1'b1; rf_waddr = rb[2:0]; rf_wdata = alu_r; end
                        OP_CALL, OP_PUSH:
                        begin rf_we = 1'b1; rf_waddr = REG_ESP; rf_wdata = a_reg; end
                        OP_RET, OP_POP:
                        begin rf_we = 1'b1; rf_waddr = REG_ESP; rf_wdata = a_reg + 32'd4; end
                        OP_MOVSB:
                        begin
                            rf_we    = 1'b1;
                            rf_waddr = ra[2:0];
                            rf_wdata = {{24{ld_reg[7]}}, ld_reg[7:0]};
                        end
                        default: rf_we = 1'b0;
                    endcase
                end
            ST_WB2:
            begin
                rf_we    = 1'b1;
                rf_waddr = ra[2:0];
                rf_wdata = ld_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // control state: sequencer, pc, status, flags, register valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            pc_reg     <= '0;
            status_reg <= STAT_RUN;
            flags_reg  <= '0;
            kind_reg   <= KIND_NONE;
            rvalid_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we)
            begin
                rvalid_reg[rf_waddr] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        kind_reg <= KIND_NONE;
                        if (item.cmd == CMD_START)
                        begin
                            pc_reg     <= PCW'(item.address);
                            status_reg <= STAT_RUN;
                        end
                    end
                ST_FETCH0:
                    if (pc_fault)
                        status_reg <= STAT_ADR;
                ST_DECODE:
                begin
                    cnt_reg <= (dec.len == 3'd1) ? 3'd0 : 3'd1;
                    if (!dec.ok)
                        status_reg <= STAT_INS;
                    else if (fetch_fault)
                        status_reg <= STAT_ADR;
                    else if (mem_rdata == OP_HALT)
                        status_reg <= STAT_HLT;
                end
                ST_FETCH:
                    cnt_reg <= (cnt_reg == len_reg - 3'd1) ? 3'd0 : cnt_reg + 3'd1;
                ST_REGS:
                begin
                    cnt_reg <= (cnt_reg == 3'd3) ? 3'd0 : cnt_reg + 3'd1;
                    if (cnt_reg == 3'd0 && nib_fault)
                        status_reg <= STAT_INS;
                end
                ST_ADDR:
                begin
                    cnt_reg <= 3'd0;
                    if (data_fault || nx_fault)
                        status_reg <= STAT_ADR;
                end
                ST_LOAD:
                    cnt_reg <= (cnt_reg == n_reg) ? 3'd0 : cnt_reg + 3'd1;
                ST_STORE:
                    cnt_reg <= (cnt_reg == n_reg - 3'd1) ? 3'd0 : cnt_reg + 3'd1;
                ST_WB:
                    if (op == OP_RET && ret_fault)
                        status_reg <= STAT_ADR;
                    else
                    begin
                        pc_reg <= (op == OP_RET) ? PCW'(ld_reg) : PCW'(nx_reg);
                        if (op inside {[OP_ADD:OP_CMP]})
                            flags_reg <= alu_flags;
                        else if (op == OP_RDB || op == OP_RDL)
                            flags_reg.zf <= rend_reg;
                        if (op == OP_WRB)
                            kind_reg <= KIND_BYTE;
                        else if (op == OP_WRL)
                            kind_reg <= KIND_LONG;
                    end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        rvld_q_reg <= rvalid_reg[rf_raddr];
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    rv_reg   <= item.read_value;
                    rend_reg <= item.read_end;
                end
            ST_DECODE:
            begin
                ib_reg[0] <= mem_rdata;
                len_reg   <= dec.len;
                used_reg  <= dec.regs_used;
            end
            ST_FETCH: ib_reg[cnt_reg] <= mem_rdata;
            ST_REGS:
                case (cnt_reg)
                    3'd1:    x_reg  <= rf_rdata;
                    3'd2:    y_reg  <= rf_rdata;
                    3'd3:    sp_reg <= rf_rdata;
                    default: x_reg  <= x_reg;
                endcase
            ST_ADDR:
            begin
                a_reg  <= a_c;
                n_reg  <= n_c;
                nx_reg <= nx_c;
                ld_reg <= 32'd0;
                case (op)
                    OP_CALL:        wval_reg <= 32'(pc_reg) + 32'd5;
                    OP_RDB, OP_RDL: wval_reg <= rv_reg;
                    default:        wval_reg <= x_reg;
                endcase
            end
            ST_LOAD:
                if (cnt_reg != 3'd0)
                    ld_reg[{ld_idx, 3'b000} +: 8] <= mem_rdata;
            ST_WB:
                if (op == OP_WRB)
                    val_reg <= {24'd0, ld_reg[7:0]};
                else
                    val_reg <= ld_reg;
            default: rv_reg <= rv_reg;
        endcase
    end

    // result transfer
    assign busy             = state_reg != ST_IDLE;
    assign done             = state_reg == ST_DONE;
    assign result.status    = status_reg;
    assign result.pc_now    = pc_reg[11:0];
    assign result.out_kind  = kind_reg;
    assign result.out_value = (kind_reg == KIND_NONE) ? 32'sd0 : $signed(val_reg);

endmodule

### design/y86_chk.sv
// Port-level assertion checker for the Y86 instruction executor, with its bind.
module y86_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input y86_pkg::item_t   item,
    input logic             done,
    input y86_pkg::result_t result
);
    import y86_pkg::*;

    // a transfer makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // a result is shown only while busy, for one cycle
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result held longer than one cycle");

    // output only from a running machine, and never a reserved kind
    a_kind_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_kind != KIND_NONE |-> result.status == STAT_RUN
        && (result.out_kind == KIND_BYTE || result.out_kind == KIND_LONG))
        else $error("output from a stopped machine or bad kind");

endmodule

bind y86_instruction_executor y86_chk u_y86_chk (.*);

### verif/tb_y86_instruction_executor.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Y86 instruction executor: directed rows, then random programs.
module tb_y86_instruction_executor;
    import y86_pkg::*;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam int         MEM_SIZE  = 4096;
    localparam int         ITEM_GOAL = 1750;

    localparam logic [7:0] OP_LIST [28] = '{OP_NOP, OP_HALT, OP_RRMOV, OP_IRMOV, OP_RMMOV,
        OP_MRMOV, OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_MUL, OP_CMP, OP_JMP, OP_JLE, OP_JL,
        OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL, OP_RET, OP_PUSH, OP_POP, OP_RDB, OP_RDL,
        OP_WRB, OP_WRL, OP_MOVSB};
    localparam logic [31:0] WORD_EDGES [5] = '{32'h0, 32'h1, 32'h7fffffff, 32'h80000000,
        32'hffffffff};

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    item_t   item;
    result_t result;

    y86_instruction_executor #(.MEM_BYTES(MEM_SIZE)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Machine state mirrored by the predictor
    logic [7:0]  mem_model [MEM_SIZE];
    bit          mem_known [MEM_SIZE];
    logic [31:0] reg_model [8];
    int unsigned pc_model;
    bit          zf_m, sf_m, of_m;
    logic [1:0]  stat_m;

    // Snapshot used while checking which bytes an instruction would touch
    logic [7:0]  mem_save [MEM_SIZE];
    bit          known_save [MEM_SIZE];
    logic [31:0] reg_save [8];
    int unsigned pc_save;
    bit          zf_s, sf_s, of_s;
    logic [1:0]  stat_s;

    int gap_addr;

    result_t pending_results [$];
    result_t want_now;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;
    row_t directed_rows [$];

    int idle_pct;
    int n_errors;
    int n_sent;
    int n_results;
    int n_exec;
    int n_writes;
    int n_stops;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // Reads a byte; notes the first byte never written
    function automatic logic [7:0] peek(input int unsigned adr);
        if (!mem_known[adr] && gap_addr < 0)
            gap_addr = adr;
        return mem_model[adr];
    endfunction

    function automatic void set_flags(input logic [31:0] r, input bit ovf);
        zf_m = (r == 32'h0);
        sf_m = r[31];
        of_m = ovf;
    endfunction

    function automatic void poke32(input int unsigned adr, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
        begin
            mem_model[adr + i] = v[8*i +: 8];
            mem_known[adr + i] = 1'b1;
        end
    endfunction

    function automatic void save_model();
        mem_save = mem_model;
        known_save = mem_known;
        reg_save = reg_model;
        pc_save = pc_model;
        {zf_s, sf_s, of_s, stat_s} = {zf_m, sf_m, of_m, stat_m};
    endfunction

    function automatic void restore_model();
        mem_model = mem_save;
        mem_known = known_save;
        reg_model = reg_save;
        pc_model = pc_save;
        {zf_m, sf_m, of_m, stat_m} = {zf_s, sf_s, of_s, stat_s};
    endfunction

    // One instruction at pc_model; faults leave everything but the status alone
    function automatic void run_instr(input logic [31:0] rv, input bit rend,
                                      output logic [1:0] kind, output logic [31:0] val);
        logic [7:0]  op;
        logic [7:0]  ib [6];
        int          len;
        bit          use_a, use_b, take;
        logic [3:0]  ra, rb;
        logic [31:0] imm, x, y, a, d, r;
        int unsigned nx;
        int          n;
        longint      p;
        kind = KIND_NONE;
        val = 32'h0;
        ib = '{default: 8'h0};
        use_a = 1'b0;
        use_b = 1'b0;
        op = peek(pc_model);
        case (op)
            OP_NOP, OP_HALT, OP_RET: len = 1;
            OP_RRMOV, OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_MUL, OP_CMP:
            begin
                len = 2;
                use_a = 1'b1;
                use_b = 1'b1;
            end
            OP_IRMOV:
            begin
                len = 6;
                use_b = 1'b1;
            end
            OP_RMMOV, OP_MRMOV, OP_MOVSB:
            begin
                len = 6;
                use_a = 1'b1;
                use_b = 1'b1;
            end
            OP_JMP, OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL: len = 5;
            OP_PUSH, OP_POP:
            begin
                len = 2;
                use_a = 1'b1;
            end
            OP_RDB, OP_RDL, OP_WRB, OP_WRL:
            begin
                len = 6;
                use_a = 1'b1;
            end
            default:
            begin
                stat_m = STAT_INS;
                return;
            end
        endcase
        if (pc_model + len > MEM_SIZE)
        begin
            stat_m = STAT_ADR;
            return;
        end
        for (int i = 1; i < len; i++)
            ib[i] = peek(pc_model + i);
        ra = ib[1][7:4];
        rb = ib[1][3:0];
        if ((use_a && ra > 4'd7) || (use_b && rb > 4'd7))
        begin
            stat_m = STAT_INS;
            return;
        end
        if (op == OP_HALT)
        begin
            stat_m = STAT_HLT;
            return;
        end
        imm = (len == 6) ? {ib[5], ib[4], ib[3], ib[2]} : {ib[4], ib[3], ib[2], ib[1]};
        x = reg_model[ra[2:0]];
        y = reg_model[rb[2:0]];
        nx = pc_model + len;
        a = 32'h0;
        n = 0;
        take = 1'b0;

        // Data address and branch decision
        case (op)
            OP_RMMOV, OP_MRMOV:
            begin
                a = y + imm;
                n = 4;
            end
            OP_MOVSB:
            begin
                a = y + imm;
                n = 1;
            end
            OP_RDB, OP_WRB:
            begin
                a = x + imm;
                n = 1;
            end
            OP_RDL, OP_WRL:
            begin
                a = x + imm;
                n = 4;
            end
            OP_CALL, OP_PUSH:
            begin
                a = reg_model[REG_ESP] - 32'd4;
                n = 4;
            end
            OP_RET, OP_POP:
            begin
                a = reg_model[REG_ESP];
                n = 4;
            end
            OP_JMP: take = 1'b1;
            OP_JLE: take = (sf_m ^ of_m) | zf_m;
            OP_JL:  take = sf_m ^ of_m;
            OP_JE:  take = zf_m;
            OP_JNE: take = !zf_m;
            OP_JGE: take = !(sf_m ^ of_m);
            OP_JG:  take = !(sf_m ^ of_m) && !zf_m;
            default: ;
        endcase
        if (op == OP_CALL || take)
            nx = imm;
        if (n > 0 && longint'(a) + n > MEM_SIZE)
        begin
            stat_m = STAT_ADR;
            return;
        end
        d = 32'h0;
        if (op inside {OP_MRMOV, OP_RET, OP_POP, OP_WRB, OP_WRL, OP_MOVSB})
            for (int i = 0; i < n; i++)
                d[8*i +: 8] = peek(a + i);
        if (op == OP_RET)
            nx = d;
        if (nx >= MEM_SIZE)
        begin
            stat_m = STAT_ADR;
            return;
        end

        // Commit
        case (op)
            OP_RRMOV: reg_model[rb[2:0]] = x;
            OP_IRMOV: reg_model[rb[2:0]] = imm;
            OP_RMMOV: poke32(a, x);
            OP_MRMOV: reg_model[ra[2:0]] = d;
            OP_ADD:
            begin
                r = y + x;
                set_flags(r, bit'((~(x ^ y) & (x ^ r)) >> 31));
                reg_model[rb[2:0]] = r;
            end
            OP_SUB, OP_CMP:
            begin
                r = y - x;
                set_flags(r, bit'(((x ^ y) & (y ^ r)) >> 31));
                if (op == OP_SUB)
                    reg_model[rb[2:0]] = r;
            end
            OP_AND:
            begin
                r = x & y;
                set_flags(r, 1'b0);
                reg_model[rb[2:0]] = r;
            end
            OP_XOR:
            begin
                r = x ^ y;
                set_flags(r, 1'b0);
                reg_model[rb[2:0]] = r;
            end
            OP_MUL:
            begin
                p = longint'($signed(x)) * longint'($signed(y));
                r = p[31:0];
                set_flags(r, longint'($signed(r)) != p);
                reg_model[rb[2:0]] = r;
            end
            OP_CALL:
            begin
                poke32(a, pc_model + 5);
                reg_model[REG_ESP] = a;
            end
            OP_RET: reg_model[REG_ESP] = a + 32'd4;
            OP_PUSH:
            begin
                poke32(a, x);
                reg_model[REG_ESP] = a;
            end
            OP_POP:
            begin
                reg_model[REG_ESP] = a + 32'd4;
                reg_model[ra[2:0]] = d;
            end
            OP_RDB, OP_RDL:
            begin
                zf_m = rend;
                if (!rend && op == OP_RDB)
                begin
                    mem_model[a] = rv[7:0];
                    mem_known[a] = 1'b1;
                end
                else if (!rend)
                    poke32(a, rv);
            end
            OP_WRB:
            begin
                kind = KIND_BYTE;
                val = {24'h0, d[7:0]};
            end
            OP_WRL:
            begin
                kind = KIND_LONG;
                val = d;
            end
            OP_MOVSB: reg_model[ra[2:0]] = {{24{d[7]}}, d[7:0]};
            default: ;
        endcase
        pc_model = nx;
    endfunction

    function automatic void predict_item(input item_t it, output result_t r);
        logic [1:0]  kind;
        logic [31:0] val;
        gap_addr = -1;
        kind = KIND_NONE;
        val = 32'h0;
        case (it.cmd)
            CMD_LOAD:
            begin
                mem_model[it.address] = it.byte_value;
                mem_known[it.address] = 1'b1;
            end
            CMD_START:
            begin
                pc_model = it.address;
                stat_m = STAT_RUN;
            end
            CMD_EXEC:
                if (stat_m == STAT_RUN)
                    run_instr(it.read_value, it.read_end, kind, val);
            default: ;
        endcase
        r = '{status: stat_m, pc_now: pc_model[11:0], out_kind: kind, out_value: val};
    endfunction

    function automatic item_t rand_item(input logic [1:0] c);
        item_t it;
        it = '{cmd: c, address: 12'($urandom), byte_value: 8'($urandom),
               read_value: $urandom, read_end: 1'($urandom)};
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] c, input logic [11:0] adr,
                                    input logic [7:0] b, input bit typed,
                                    input logic [1:0] st, input logic [11:0] pcv);
        row_t row;
        row.it = rand_item(c);
        row.it.address = adr;
        row.it.byte_value = b;
        row.typed = typed;
        row.want = '{status: st, pc_now: pcv, out_kind: KIND_NONE, out_value: 32'sh0};
        directed_rows.push_back(row);
    endfunction

    // Drives one item and records its expected result at the transfer
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t guess;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        predict_item(it, guess);
        pending_results.push_back(typed ? want : guess);
        n_sent++;
        if (it.cmd == CMD_EXEC)
            n_exec++;
    endtask

    // Fills any never-written byte the instruction would read, then executes it
    task automatic issue_exec(input logic [31:0] rv, input bit rend);
        item_t   it;
        item_t   ld;
        result_t tmp;
        it = rand_item(CMD_EXEC);
        it.read_value = rv;
        it.read_end = rend;
        forever
        begin
            save_model();
            predict_item(it, tmp);
            restore_model();
            if (gap_addr < 0)
                break;
            ld = rand_item(CMD_LOAD);
            ld.address = gap_addr[11:0];
            send_item(ld, 1'b0, tmp);
        end
        send_item(it, 1'b0, tmp);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", {30'h0, result.status}, 32'h0);
            else
            begin
                want_now = pending_results.pop_front();
                n_results++;
                if (result.status != want_now.status)
                    report_mismatch("status", result.status, want_now.status);
                if (result.pc_now != want_now.pc_now)
                    report_mismatch("pc_now", result.pc_now, want_now.pc_now);
                if (result.out_kind != want_now.out_kind)
                    report_mismatch("out_kind", result.out_kind, want_now.out_kind);
                if (result.out_value != want_now.out_value)
                    report_mismatch("out_value", result.out_value, want_now.out_value);
                if (want_now.out_kind != KIND_NONE)
                    n_writes++;
                if (want_now.status != STAT_RUN)
                    n_stops++;
            end
        end
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_y86_instruction_executor: done, errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [7:0]  prog [$];
        logic [7:0]  op, rbyte;
        logic [31:0] imm, rv;
        int          nins, base, roll, steps;
        decode_t     dec;
        item_t       it;
        result_t     none;

        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        none = '0;
        idle_pct = 11;
        foreach (mem_model[i])
        begin
            mem_model[i] = 8'h0;
            mem_known[i] = 1'b0;
        end
        foreach (reg_model[i])
            reg_model[i] = 32'h0;
        pc_model = 0;
        {zf_m, sf_m, of_m} = 3'b000;
        stat_m = STAT_RUN;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unused command, halt, stopped machine, invalid opcode, fetch past
        // memory, bad register nibble, push with a wrapped stack address
        add_row(CMD_NONE,  12'd0,    8'h00,    1, STAT_RUN, 12'd0);
        add_row(CMD_LOAD,  12'd4095, 8'hff,    1, STAT_RUN, 12'd0);
        add_row(CMD_LOAD,  12'd0,    OP_HALT,  1, STAT_RUN, 12'd0);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_HLT, 12'd0);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_HLT, 12'd0);
        add_row(CMD_START, 12'd4095, 8'h00,    1, STAT_RUN, 12'd4095);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_INS, 12'd4095);
        add_row(CMD_LOAD,  12'd4094, OP_IRMOV, 1, STAT_INS, 12'd4095);
        add_row(CMD_START, 12'd4094, 8'h00,    1, STAT_RUN, 12'd4094);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_ADR, 12'd4094);
        add_row(CMD_LOAD,  12'd8,    OP_RRMOV, 1, STAT_ADR, 12'd4094);
        add_row(CMD_LOAD,  12'd9,    8'h8f,    1, STAT_ADR, 12'd4094);
        add_row(CMD_START, 12'd8,    8'h00,    1, STAT_RUN, 12'd8);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_INS, 12'd8);
        add_row(CMD_LOAD,  12'd8,    OP_PUSH,  1, STAT_INS, 12'd8);
        add_row(CMD_LOAD,  12'd9,    8'h4f,    1, STAT_INS, 12'd8);
        add_row(CMD_START, 12'd8,    8'h00,    1, STAT_RUN, 12'd8);
        add_row(CMD_EXEC,  12'd0,    8'h00,    1, STAT_ADR, 12'd8);
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        // Random programs: load, set start, run
        while (n_sent < ITEM_GOAL)
        begin
            idle_pct = (n_sent < ITEM_GOAL / 3) ? 11 : (n_sent < 2 * ITEM_GOAL / 3) ? 53 : 0;
            nins = $urandom_range(3, 10);
            base = ($urandom_range(99) < 8) ? MEM_SIZE - nins * 6 - 2 :
                   $urandom_range(0, MEM_SIZE - nins * 6 - 14);
            prog.delete();
            if ($urandom_range(1))
                prog = '{OP_IRMOV, {4'hf, 1'b0, REG_ESP}, 8'($urandom_range(16, 255)),
                         8'($urandom_range(0, 15)), 8'h0, 8'h0};
            for (int k = 0; k < nins; k++)
            begin
                op = ($urandom_range(99) < 93) ? OP_LIST[$urandom_range(27)] : 8'($urandom);
                rbyte = ($urandom_range(99) < 95) ? {1'b0, 3'($urandom), 1'b0, 3'($urandom)} :
                        8'($urandom);
                roll = $urandom_range(99);
                dec = y86_decode(op);
                if (op == OP_IRMOV)
                    imm = (roll < 50) ? 32'($urandom_range(0, 4095)) :
                          (roll < 75) ? $urandom : WORD_EDGES[$urandom_range(4)];
                else if (dec.len == 3'd5)
                    imm = (roll < 70) ? 32'(base + $urandom_range(0, nins * 6)) :
                          (roll < 90) ? 32'($urandom_range(0, 4095)) : $urandom;
                else
                    imm = (roll < 60) ? 32'($urandom_range(0, 64)) :
                          (roll < 80) ? -32'($urandom_range(1, 16)) : $urandom;
                prog.push_back(op);
                if (dec.len == 3'd2 || dec.len == 3'd6)
                    prog.push_back(rbyte);
                if (dec.len >= 3'd5)
                    for (int i = 0; i < 4; i++)
                        prog.push_back(imm[8*i +: 8]);
            end
            foreach (prog[i])
            begin
                it = rand_item(CMD_LOAD);
                it.address = 12'(base + i);
                it.byte_value = prog[i];
                send_item(it, 1'b0, none);
            end
            it = rand_item(CMD_START);
            it.address = 12'(base);
            send_item(it, 1'b0, none);

            steps = nins + 3;
            for (int s = 0; s < steps; s++)
            begin
                if (stat_m != STAT_RUN && $urandom_range(99) < 70)
                    break;
                if ($urandom_range(99) < 4)
                    send_item(rand_item($urandom_range(1) ? CMD_NONE : CMD_LOAD), 1'b0, none);
                case ($urandom_range(5))
                    0:       rv = WORD_EDGES[0];
                    1:       rv = WORD_EDGES[2];
                    2:       rv = WORD_EDGES[3];
                    3:       rv = WORD_EDGES[4];
                    default: rv = $urandom;
                endcase
                issue_exec(rv, $urandom_range(99) < 15);
            end
        end
        start <= 1'b0;

        // Drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Ran %0d items (%0d executed), checked %0d results.", n_sent, n_exec,
                 n_results);
        $display("Outputs written: %0d, results with a stopped machine: %0d, mismatches: %0d",
                 n_writes, n_stops, n_errors);
        if (n_errors == 0)
            $display("tb_y86_instruction_executor: done, clean");
        else
            $display("tb_y86_instruction_executor: done, errors");
        $finish;
    end

endmodule

### sim.f
design/y86_pkg.sv
design/y86_ram.sv
design/y86_alu.sv
design/y86_instruction_executor.sv
design/y86_chk.sv
verif/tb_y86_instruction_executor.sv
